FILE: src/swiglu_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and the sigmoid table builder for the swiglu activation unit
// no dependencies; used by every module of the block
package swiglu_pkg;

   localparam int SEGMENTS_DEFAULT = 64;
   localparam int DATA_W           = 16;
   localparam int ABS_W            = 15;   // |gate| capped at 32767
   localparam int FRAC_W           = 9;    // interpolation fraction bits
   localparam int KEY_W            = ABS_W - FRAC_W;
   localparam int SIG_W            = 16;   // 15 fraction bits, 32768 means 1.0
   localparam int DELTA_W          = 11;   // largest neighbor step of the table is near 1022
   localparam int P1_W             = 32;   // gate*sig, magnitude up to 2^30
   localparam int P2_W             = 48;   // gate*sig*up, magnitude up to 2^45
   localparam int RND_SHIFT        = 27;
   localparam int RES_W            = P2_W - RND_SHIFT;
   localparam logic [SIG_W-1:0] SIG_ONE = 16'h8000;

   typedef struct packed {
      logic signed [DATA_W-1:0] gate;
      logic signed [DATA_W-1:0] up;
      logic [SIG_W-1:0]         sig;
      logic                     last;
   } sig_item_type;

   // round(32768 / (1 + exp(-j/8))) written as 16384 * (1 + tanh(j/16)), elaboration only
   function automatic logic [SIG_W-1:0] sig_entry(input int j);
      real x;
      x = 16384.0 * (1.0 + $tanh(j * 0.0625));
      return SIG_W'($rtoi(x + 0.5));
   endfunction

endpackage

FILE: src/swiglu_sigmoid.sv
`timescale 1ns / 1ps
// three-stage sigmoid: |gate| split, table lookup, linear interpolation and mirroring
// depends on swiglu_pkg
module swiglu_sigmoid import swiglu_pkg::*; #(
   parameter int SEGMENTS = SEGMENTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  logic signed [DATA_W-1:0] in_gate,
   input  logic signed [DATA_W-1:0] in_up,
   input  logic                     in_last,
   output logic                     out_valid,
   input  logic                     out_stall,
   output sig_item_type             out_item
);

   localparam int IDX_W = $clog2(SEGMENTS + 1);

   logic [SIG_W-1:0] lut [SEGMENTS+1];

   for (genvar j = 0; j <= SEGMENTS; j++) begin : g_lut
      assign lut[j] = sig_entry(j);
   end

   logic adv1, adv2, adv3;

   // stage 1: magnitude split
   logic                     v1_ff;
   logic signed [DATA_W-1:0] gate1_ff, up1_ff;
   logic                     last1_ff;
   logic [KEY_W-1:0]         key1_ff;
   logic [FRAC_W-1:0]        frac1_ff;
   logic [ABS_W-1:0]         mag1_in;

   // stage 2: table words
   logic                     v2_ff;
   logic signed [DATA_W-1:0] gate2_ff, up2_ff;
   logic                     last2_ff;
   logic [FRAC_W-1:0]        frac2_ff;
   logic [SIG_W-1:0]         lo2_ff, lo2_in;
   logic [DELTA_W-1:0]       delta2_ff, delta2_in;
   logic [IDX_W-1:0]         lo_idx, hi_idx;

   // stage 3: interpolated sigmoid
   logic                     v3_ff;
   sig_item_type             item3_ff, item3_in;
   logic [DELTA_W+FRAC_W-1:0] ramp;
   logic [SIG_W-1:0]         t3;

   assign adv3     = !v3_ff || !out_stall;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_stall = !adv1;

   always_comb begin
      if (in_gate == {1'b1, {(DATA_W-1){1'b0}}}) begin
         mag1_in = {ABS_W{1'b1}};
      end else if (in_gate[DATA_W-1]) begin
         mag1_in = ABS_W'(-in_gate);
      end else begin
         mag1_in = ABS_W'(in_gate);
      end
   end

   // an index past the table end holds at the last entry, so the step is zero
   always_comb begin
      if (32'(key1_ff) >= SEGMENTS) begin
         lo_idx = IDX_W'(SEGMENTS);
      end else begin
         lo_idx = IDX_W'(key1_ff);
      end
      if (32'(key1_ff) + 32'd1 >= SEGMENTS) begin
         hi_idx = IDX_W'(SEGMENTS);
      end else begin
         hi_idx = IDX_W'(32'(key1_ff) + 32'd1);
      end
      lo2_in    = lut[lo_idx];
      delta2_in = DELTA_W'(lut[hi_idx] - lut[lo_idx]);
   end

   always_comb begin
      ramp          = DELTA_W'(delta2_ff) * (DELTA_W+FRAC_W)'(frac2_ff);
      t3            = lo2_ff + SIG_W'(ramp >> FRAC_W);
      item3_in.gate = gate2_ff;
      item3_in.up   = up2_ff;
      item3_in.last = last2_ff;
      item3_in.sig  = gate2_ff[DATA_W-1] ? SIG_ONE - t3 : t3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         gate1_ff <= in_gate;
         up1_ff   <= in_up;
         last1_ff <= in_last;
         key1_ff  <= mag1_in[ABS_W-1:FRAC_W];
         frac1_ff <= mag1_in[FRAC_W-1:0];
      end
      if (adv2) begin
         gate2_ff  <= gate1_ff;
         up2_ff    <= up1_ff;
         last2_ff  <= last1_ff;
         frac2_ff  <= frac1_ff;
         lo2_ff    <= lo2_in;
         delta2_ff <= delta2_in;
      end
      if (adv3) begin
         item3_ff <= item3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = item3_ff;

endmodule

FILE: src/swiglu_product.sv
`timescale 1ns / 1ps
// three-stage product: gate*sig, times up, then round half up and saturate
// depends on swiglu_pkg
module swiglu_product import swiglu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  sig_item_type             in_item,
   output logic                     out_valid,
   input  logic                     out_stall,
   output logic signed [DATA_W-1:0] out_product,
   output logic                     out_saturated,
   output logic                     out_last
);

   localparam logic signed [P2_W-1:0] RND_HALF = P2_W'(1) <<< (RND_SHIFT - 1);
   localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(32767);
   localparam logic signed [RES_W-1:0] RES_MIN = -RES_W'(32768);

   logic adv4, adv5, adv6;

   logic                     v4_ff;
   logic signed [P1_W-1:0]   p1_ff;
   logic signed [DATA_W-1:0] up4_ff;
   logic                     last4_ff;

   logic                     v5_ff;
   logic signed [P2_W-1:0]   p2_ff;
   logic                     last5_ff;

   logic                     v6_ff;
   logic signed [DATA_W-1:0] prod6_ff, prod6_in;
   logic                     sat6_ff, sat6_in;
   logic                     last6_ff;

   logic signed [P2_W-1:0]   rounded;
   logic signed [RES_W-1:0]  res;

   assign adv6     = !v6_ff || !out_stall;
   assign adv5     = !v5_ff || adv6;
   assign adv4     = !v4_ff || adv5;
   assign in_stall = !adv4;

   // floor shift after the half bias gives round half up for both signs
   always_comb begin
      rounded = p2_ff + RND_HALF;
      res     = rounded[P2_W-1:RND_SHIFT];
      if (res > RES_MAX) begin
         prod6_in = DATA_W'(RES_MAX);
         sat6_in  = 1'b1;
      end else if (res < RES_MIN) begin
         prod6_in = DATA_W'(RES_MIN);
         sat6_in  = 1'b1;
      end else begin
         prod6_in = DATA_W'(res);
         sat6_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (adv4) v4_ff <= in_valid;
         if (adv5) v5_ff <= v4_ff;
         if (adv6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         p1_ff    <= P1_W'(in_item.gate) * P1_W'($signed({1'b0, in_item.sig}));
         up4_ff   <= in_item.up;
         last4_ff <= in_item.last;
      end
      if (adv5) begin
         p2_ff    <= P2_W'(p1_ff) * P2_W'(up4_ff);
         last5_ff <= last4_ff;
      end
      if (adv6) begin
         prod6_ff <= prod6_in;
         sat6_ff  <= sat6_in;
         last6_ff <= last5_ff;
      end
   end

   assign out_valid     = v6_ff;
   assign out_product   = prod6_ff;
   assign out_saturated = sat6_ff;
   assign out_last      = last6_ff;

endmodule

FILE: src/swiglu_activation_unit.sv
`timescale 1ns / 1ps
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | gate_value, up_value, last_in
//  rsp     | out       | rsp_valid/rsp_stall  | product_out, saturated, last_out
//
// one item enters per cycle while req_stall is low; each item passes the three sigmoid stages
// (split, table read, interpolation) and the three product stages (two multiplies, rounding)
// reset is synchronous and clears only the stage valid bits
// each stage moves whenever the stage after it is empty or moving, so a stall on rsp
// fills bubbles first and reaches req_stall only when all six stages hold items
// depends on swiglu_pkg, swiglu_sigmoid, swiglu_product
module swiglu_activation_unit import swiglu_pkg::*; #(
   parameter int SEGMENTS = SEGMENTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_gate_value,
   input  logic signed [DATA_W-1:0] req_up_value,
   input  logic                     req_last_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_product_out,
   output logic                     rsp_saturated,
   output logic                     rsp_last_out
);

   logic         mid_valid;
   logic         mid_stall;
   sig_item_type mid_item;

   swiglu_sigmoid #(
      .SEGMENTS (SEGMENTS)
   ) u_sigmoid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_gate   (req_gate_value),
      .in_up     (req_up_value),
      .in_last   (req_last_in),
      .out_valid (mid_valid),
      .out_stall (mid_stall),
      .out_item  (mid_item)
   );

   swiglu_product u_product (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (mid_valid),
      .in_stall      (mid_stall),
      .in_item       (mid_item),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .out_product   (rsp_product_out),
      .out_saturated (rsp_saturated),
      .out_last      (rsp_last_out)
   );

endmodule

FILE: src/swiglu_checker.sv
`timescale 1ns / 1ps
// port-level assertions for the swiglu activation unit, bound to the top level
// depends on swiglu_pkg and swiglu_activation_unit
module swiglu_checker import swiglu_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [DATA_W-1:0] rsp_product_out,
   input logic                     rsp_saturated,
   input logic                     rsp_last_out
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // an empty output register means the pipeline can always take an item
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output is empty");

   // backpressure only comes from the result side
   a_stall_from_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while results drain freely");

   // a clipped item sits exactly on one of the bounds
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_product_out == 16'sh7fff || rsp_product_out == 16'sh8000)
      else $error("saturated item not at a bound");

   // a stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_product_out) && $stable(rsp_saturated)
         && $stable(rsp_last_out))
      else $error("stalled item changed");

endmodule

bind swiglu_activation_unit swiglu_checker u_swiglu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_product_out (rsp_product_out),
   .rsp_saturated   (rsp_saturated),
   .rsp_last_out    (rsp_last_out)
);
